[sv/gds_pkg.sv]
// gds_pkg: constants, record types and calendar helpers of the gregorian date stepper
// no dependencies; used by the interfaces, gds_step_unit and gregorian_date_stepper
`timescale 1ns / 1ps
`default_nettype none

package gds_pkg;

    // field widths of the word formats
    localparam int CMD_W   = 2;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 12;

    // number of low day_count bits in use
    localparam int MAX_COUNT_BITS = 12;
    localparam int CNT_W          = MAX_COUNT_BITS;
    // compare width: wide enough for a count and for a day value plus one
    localparam int CMP_W          = (CNT_W > 6) ? CNT_W : 6;

    // year limits
    localparam int                MIN_YEAR   = 1900;
    localparam logic [YEAR_W-1:0] MIN_YEAR_V = YEAR_W'(MIN_YEAR);
    localparam logic [YEAR_W-1:0] TOP_YEAR_V = YEAR_W'(9999);

    // residues of the reset year
    localparam logic [1:0] MIN_MOD4   = 2'(MIN_YEAR % 4);
    localparam logic [6:0] MIN_MOD100 = 7'(MIN_YEAR % 100);
    localparam logic [1:0] MIN_CENT4  = 2'((MIN_YEAR / 100) % 4);

    // divide by 100 as multiply by reciprocal, exact for 14-bit years
    localparam int                DIV100_SHIFT = 19;
    localparam logic [12:0]       DIV100_MUL   = 13'd5243;
    localparam int                PROD_W       = YEAR_W + 13;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd2;

    // month numbers with special handling
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // current date plus running residues of the year for the leap rule
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [1:0]         ymod4;
        logic [6:0]         ymod100;
        logic [1:0]         cent4;
    } cal_t;

    // result of one stepping pass
    typedef struct packed {
        cal_t             nxt;
        logic [CNT_W-1:0] cnt_next;
        logic             done;
        logic             lim;
    } step_res_t;

    // leap rule from the residues: by 4 and not by 100, or by 400
    function automatic logic leap_of(input logic [1:0] ymod4, input logic [6:0] ymod100,
                                     input logic [1:0] cent4);
        logic by100;
        by100 = (ymod100 == 7'd0);
        return ((ymod4 == 2'd0) && !by100) || (by100 && (cent4 == 2'd0));
    endfunction

    // days in a month, zero for a month code out of range
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            MONTH_FEB:              len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            [4'd1:4'd12]:           len = 5'd31;
            default:                len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[sv/gds_if.sv]
// gds_req_if and gds_rsp_if: valid/ready channels for command and result words
// depends on gds_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface gds_req_if;
    import gds_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [YEAR_W-1:0]  new_year;
    logic [COUNT_W-1:0] day_count;

    modport source (output valid, command, new_day, new_month, new_year, day_count,
                    input ready);
    modport sink   (input valid, command, new_day, new_month, new_year, day_count,
                    output ready);
endinterface

interface gds_rsp_if;
    import gds_pkg::*;

    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic               set_accepted;
    logic               limit_hit;

    modport source (output valid, out_day, out_month, out_year, set_accepted, limit_hit,
                    input ready);
    modport sink   (input valid, out_day, out_month, out_year, set_accepted, limit_hit,
                    output ready);
endinterface

`default_nettype wire

[sv/gregorian_date_stepper.sv]
// gregorian_date_stepper: top level, command sequencer, set check and result register
// depends on gds_pkg, gds_if.sv and gds_step_unit
`timescale 1ns / 1ps
`default_nettype none

// Holds one Gregorian date (01/01/1900 after reset) and takes one command word at a time:
// set, add days or subtract days; each command returns one result word with the date and
// the set_accepted and limit_hit flags. The block takes no command while one is in work.
// A set computes the quotient by 100 through a reciprocal multiply, then runs the leap and
// range check before the result register. An add or subtract runs the shared step unit
// once per cycle, crossing at most one month boundary each pass, until the count is used
// up or a year limit is hit. An unused command code goes straight to the result and leaves
// the date unchanged. The result register lets the next command be accepted while the
// previous result still waits.
module gregorian_date_stepper (
    input  wire logic clk,
    input  wire logic rst_n,
    gds_req_if.sink   req,
    gds_rsp_if.source rsp
);
    import gds_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SET,
        S_STEP,
        S_DONE
    } state_t;

    state_t             state_reg;
    cal_t               cal_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               back_reg;
    logic [DAY_W-1:0]   nd_reg;
    logic [MONTH_W-1:0] nm_reg;
    logic [YEAR_W-1:0]  ny_reg;
    logic [7:0]         q_reg;
    logic               acc_reg;
    logic               lim_reg;
    logic               out_valid_reg;
    logic [DAY_W-1:0]   out_day_reg;
    logic [MONTH_W-1:0] out_month_reg;
    logic [YEAR_W-1:0]  out_year_reg;
    logic               out_acc_reg;
    logic               out_lim_reg;

    step_res_t          step;
    logic [PROD_W-1:0]  prod;
    logic [YEAR_W:0]    q100;
    logic [YEAR_W-1:0]  rem;
    logic               set_leap;
    logic               set_ok;
    logic               slot_free;
    logic               res_load;

    // shared stepping unit
    gds_step_unit u_step (
        .cur  (cal_reg),
        .cnt  (cnt_reg),
        .back (back_reg),
        .res  (step)
    );

    // year divided by 100 via reciprocal
    assign prod = PROD_W'(ny_reg) * PROD_W'(DIV100_MUL);

    // remainder by 100 and validity of a set word
    assign q100     = (YEAR_W+1)'({q_reg, 6'b0}) + (YEAR_W+1)'({q_reg, 5'b0})
                    + (YEAR_W+1)'({q_reg, 2'b0});
    assign rem      = ny_reg - q100[YEAR_W-1:0];
    assign set_leap = leap_of(ny_reg[1:0], rem[6:0], q_reg[1:0]);
    assign set_ok   = (ny_reg >= MIN_YEAR_V) && (ny_reg <= TOP_YEAR_V)
                    && (nd_reg != 5'd0) && (nd_reg <= month_len(nm_reg, set_leap));

    assign slot_free = !out_valid_reg || rsp.ready;
    assign res_load  = (state_reg == S_DONE) && slot_free;

    // handshake and result word
    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.out_day      = out_day_reg;
    assign rsp.out_month    = out_month_reg;
    assign rsp.out_year     = out_year_reg;
    assign rsp.set_accepted = out_acc_reg;
    assign rsp.limit_hit    = out_lim_reg;

    // sequencer, date state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cal_reg       <= '{day: 5'd1, month: MONTH_JAN, year: MIN_YEAR_V,
                               ymod4: MIN_MOD4, ymod100: MIN_MOD100, cent4: MIN_CENT4};
            cnt_reg       <= '0;
            back_reg      <= 1'b0;
            nd_reg        <= '0;
            nm_reg        <= '0;
            ny_reg        <= '0;
            q_reg         <= '0;
            acc_reg       <= 1'b0;
            lim_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_day_reg   <= '0;
            out_month_reg <= '0;
            out_year_reg  <= '0;
            out_acc_reg   <= 1'b0;
            out_lim_reg   <= 1'b0;
        end
        else
        begin
            // result word valid flag
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        nd_reg   <= req.new_day;
                        nm_reg   <= req.new_month;
                        ny_reg   <= req.new_year;
                        cnt_reg  <= CNT_W'(req.day_count);
                        back_reg <= (req.command == CMD_SUB);
                        lim_reg  <= 1'b0;
                        case (req.command)
                            CMD_SET:
                            begin
                                acc_reg   <= 1'b0;
                                state_reg <= S_DIV;
                            end
                            CMD_ADD, CMD_SUB:
                            begin
                                acc_reg   <= 1'b1;
                                state_reg <= S_STEP;
                            end
                            default:
                            begin
                                acc_reg   <= 1'b0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    q_reg     <= prod[PROD_W-1:DIV100_SHIFT];
                    state_reg <= S_SET;
                end
                S_SET:
                begin
                    acc_reg <= set_ok;
                    if (set_ok)
                    begin
                        cal_reg <= '{day: nd_reg, month: nm_reg, year: ny_reg,
                                     ymod4: ny_reg[1:0], ymod100: rem[6:0],
                                     cent4: q_reg[1:0]};
                    end
                    state_reg <= S_DONE;
                end
                S_STEP:
                begin
                    cal_reg <= step.nxt;
                    cnt_reg <= step.cnt_next;
                    if (step.done)
                    begin
                        lim_reg   <= step.lim;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_load)
                    begin
                        out_day_reg   <= cal_reg.day;
                        out_month_reg <= cal_reg.month;
                        out_year_reg  <= cal_reg.year;
                        out_acc_reg   <= acc_reg;
                        out_lim_reg   <= lim_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/gds_step_unit.sv]
// gds_step_unit: one stepping pass, moves the date by up to one month boundary
// depends on gds_pkg
`timescale 1ns / 1ps
`default_nettype none

module gds_step_unit (
    input  wire gds_pkg::cal_t            cur,
    input  wire logic [gds_pkg::CNT_W-1:0] cnt,
    input  wire logic                     back,
    output gds_pkg::step_res_t            res
);
    import gds_pkg::*;

    logic               leap;
    logic [DAY_W-1:0]   mlen;
    logic [DAY_W-1:0]   left;
    logic [CMP_W-1:0]   cnt_x;
    logic [CMP_W-1:0]   left_x;
    logic [CMP_W-1:0]   day_x;
    logic [MONTH_W-1:0] month_dn;

    // month length and room left in the current month
    assign leap     = leap_of(cur.ymod4, cur.ymod100, cur.cent4);
    assign mlen     = month_len(cur.month, leap);
    assign left     = mlen - cur.day;
    assign cnt_x    = CMP_W'(cnt);
    assign left_x   = CMP_W'(left);
    assign day_x    = CMP_W'(cur.day);
    assign month_dn = cur.month - 4'd1;

    // forward or backward pass
    always_comb
    begin
        res.nxt      = cur;
        res.cnt_next = cnt;
        res.done     = 1'b0;
        res.lim      = 1'b0;
        if (!back)
        begin
            if (cnt_x <= left_x)
            begin
                res.nxt.day = cur.day + cnt_x[DAY_W-1:0];
                res.done    = 1'b1;
            end
            else if ((cur.month == MONTH_DEC) && (cur.year >= TOP_YEAR_V))
            begin
                res.nxt.day = 5'd31;
                res.done    = 1'b1;
                res.lim     = 1'b1;
            end
            else
            begin
                res.cnt_next = CNT_W'(cnt_x - left_x - CMP_W'(1));
                res.nxt.day  = 5'd1;
                if (cur.month == MONTH_DEC)
                begin
                    res.nxt.month = MONTH_JAN;
                    res.nxt.year  = cur.year + 14'd1;
                    res.nxt.ymod4 = cur.ymod4 + 2'd1;
                    if (cur.ymod100 == 7'd99)
                    begin
                        res.nxt.ymod100 = 7'd0;
                        res.nxt.cent4   = cur.cent4 + 2'd1;
                    end
                    else
                    begin
                        res.nxt.ymod100 = cur.ymod100 + 7'd1;
                    end
                end
                else
                begin
                    res.nxt.month = cur.month + 4'd1;
                end
            end
        end
        else
        begin
            if (cnt_x < day_x)
            begin
                res.nxt.day = cur.day - cnt_x[DAY_W-1:0];
                res.done    = 1'b1;
            end
            else if ((cur.month == MONTH_JAN) && (cur.year <= MIN_YEAR_V))
            begin
                res.nxt.day = 5'd1;
                res.done    = 1'b1;
                res.lim     = 1'b1;
            end
            else
            begin
                res.cnt_next = CNT_W'(cnt_x - day_x);
                if (cur.month == MONTH_JAN)
                begin
                    res.nxt.month = MONTH_DEC;
                    res.nxt.day   = 5'd31;
                    res.nxt.year  = cur.year - 14'd1;
                    res.nxt.ymod4 = cur.ymod4 - 2'd1;
                    if (cur.ymod100 == 7'd0)
                    begin
                        res.nxt.ymod100 = 7'd99;
                        res.nxt.cent4   = cur.cent4 - 2'd1;
                    end
                    else
                    begin
                        res.nxt.ymod100 = cur.ymod100 - 7'd1;
                    end
                end
                else
                begin
                    // same year, so the current leap flag holds
                    res.nxt.month = month_dn;
                    res.nxt.day   = month_len(month_dn, leap);
                end
            end
        end
    end

endmodule

`default_nettype wire
